// File: rtl/rlwr_pkg.sv
// Shared constants, codes and the wave curve for the raster line wave rotator.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package rlwr_pkg;

	localparam int LINE_WIDTH_DEF      = 320;
	localparam int LINE_COUNT_DEF      = 200;
	localparam int PIXELS_PER_WORD_DEF = 8;

	localparam int WORD_W  = 64;
	localparam int PIXEL_W = 8;
	localparam int AMP_W   = 16;
	localparam int CURVE_W = 9;
	localparam int PROD_W  = AMP_W + CURVE_W;
	localparam int OFF_W   = PROD_W - 8;
	localparam int CNT_W   = 5;
	localparam int TABLE_W = 5;
	localparam int ROW_W   = 8;
	localparam int CFG_W   = 16;

	localparam logic [AMP_W-1:0] AMP_LIMIT = AMP_W'(256);
	localparam logic [ROW_W-1:0] ROW_MAX   = '1;

	localparam logic CFG_WAVE_START = 1'b0;
	localparam logic CFG_WAVE_STEP  = 1'b1;

	typedef struct packed {
		logic init;
		logic issue;
		logic bank;
	} lane_ctrl_t;

	function automatic logic [CURVE_W-1:0] curve(input logic [TABLE_W-2:0] k);
		logic [CURVE_W-1:0] v;
		case (k)
			4'd0:    v = 9'd60;
			4'd1:    v = 9'd112;
			4'd2:    v = 9'd156;
			4'd3:    v = 9'd192;
			4'd4:    v = 9'd220;
			4'd5:    v = 9'd240;
			4'd6:    v = 9'd252;
			4'd7:    v = 9'd256;
			4'd8:    v = 9'd252;
			4'd9:    v = 9'd240;
			4'd10:   v = 9'd220;
			4'd11:   v = 9'd192;
			4'd12:   v = 9'd156;
			4'd13:   v = 9'd112;
			4'd14:   v = 9'd60;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/rlwr_shift_calc.sv
// Row shift sequencer: amp*curve/256, reduced mod line width, split into word and pixel.
// Reciprocal multiplies with one correcting subtract each. Uses rlwr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlwr_shift_calc
	import rlwr_pkg::*;
#(
	parameter int LINE_WIDTH      = LINE_WIDTH_DEF,
	parameter int PIXELS_PER_WORD = PIXELS_PER_WORD_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [AMP_W-1:0]    amp,
	input  wire logic [TABLE_W-1:0]  k,
	input  wire logic                enable,
	output logic                     done,
	output logic [$clog2((LINE_WIDTH + PIXELS_PER_WORD - 1) / PIXELS_PER_WORD)-1:0] s_word,
	output logic [(PIXELS_PER_WORD > 1 ? $clog2(PIXELS_PER_WORD) : 1)-1:0]            s_bsel
);

	localparam int WPR  = (LINE_WIDTH + PIXELS_PER_WORD - 1) / PIXELS_PER_WORD;
	localparam int WW   = $clog2(WPR);
	localparam int BW   = PIXELS_PER_WORD > 1 ? $clog2(PIXELS_PER_WORD) : 1;
	localparam int SW   = $clog2(LINE_WIDTH);
	localparam int R1_W = OFF_W + 1;
	localparam int P1_W = OFF_W + R1_W;
	localparam int R2_W = SW + 1;
	localparam int P2_W = SW + R2_W;
	localparam logic [SW:0]      LW_T   = (SW + 1)'(LINE_WIDTH);
	localparam logic [OFF_W-1:0] LW_O   = OFF_W'(LINE_WIDTH);
	localparam logic [BW:0]      PPW_T  = (BW + 1)'(PIXELS_PER_WORD);
	localparam logic [SW-1:0]    PPW_S  = SW'(PIXELS_PER_WORD);
	localparam logic [R1_W-1:0]  RECIP1 = R1_W'((longint'(1) << OFF_W) / LINE_WIDTH);
	localparam logic [R2_W-1:0]  RECIP2 = R2_W'((longint'(1) << SW) / PIXELS_PER_WORD);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_REC,
		ST_MOD,
		ST_FIX,
		ST_FLIP,
		ST_DIV,
		ST_SPLIT
	} state_t;

	state_t             state_q;
	logic [AMP_W-1:0]   amp_q;
	logic [TABLE_W-1:0] k_q;
	logic               en_q;
	logic [OFF_W-1:0]   off_q;
	logic [OFF_W-1:0]   q1_q;
	logic [SW:0]        r_q;
	logic [SW-1:0]      rem_q;
	logic [SW-1:0]      s_q;
	logic [SW-1:0]      q2_q;
	logic [SW-1:0]      quo_q;
	logic [BW-1:0]      rem2_q;
	logic               done_q;

	logic [PROD_W-1:0]  prod;
	logic [P1_W-1:0]    prod1;
	logic [OFF_W-1:0]   diff1;
	logic [P2_W-1:0]    prod2;
	logic [SW-1:0]      diff2;
	logic [BW:0]        r2;

	// quotient estimates are exact or one short; one subtract corrects them
	assign prod  = PROD_W'(amp_q) * PROD_W'(curve(k_q[TABLE_W-2:0]));
	assign prod1 = P1_W'(off_q) * P1_W'(RECIP1);
	assign diff1 = off_q - q1_q * LW_O;
	assign prod2 = P2_W'(s_q) * P2_W'(RECIP2);
	assign diff2 = s_q - q2_q * PPW_S;
	assign r2    = (BW + 1)'(diff2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_REC;
				ST_REC:  state_q <= ST_MOD;
				ST_MOD:  state_q <= ST_FIX;
				ST_FIX:  state_q <= ST_FLIP;
				ST_FLIP: state_q <= ST_DIV;
				ST_DIV:  state_q <= ST_SPLIT;
				ST_SPLIT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					amp_q <= amp;
					k_q   <= k;
					en_q  <= enable;
				end
			end
			ST_MUL: begin
				off_q <= prod[PROD_W-1:8];
			end
			ST_REC: begin
				q1_q <= prod1[OFF_W +: OFF_W];
			end
			ST_MOD: begin
				r_q <= (SW + 1)'(diff1);
			end
			ST_FIX: begin
				rem_q <= (r_q >= LW_T) ? SW'(r_q - LW_T) : SW'(r_q);
			end
			ST_FLIP: begin
				if (!en_q) begin
					s_q <= '0;
				end else if (k_q[TABLE_W-1] && rem_q != '0) begin
					s_q <= SW'(LW_T - (SW + 1)'(rem_q));
				end else begin
					s_q <= rem_q;
				end
			end
			ST_DIV: begin
				q2_q <= prod2[SW +: SW];
			end
			ST_SPLIT: begin
				if (r2 >= PPW_T) begin
					quo_q  <= q2_q + 1'b1;
					rem2_q <= BW'(r2 - PPW_T);
				end else begin
					quo_q  <= q2_q;
					rem2_q <= BW'(r2);
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign s_word = quo_q[WW-1:0];
	assign s_bsel = rem2_q;

endmodule

`default_nettype wire

// File: rtl/rlwr_lane.sv
// One output pixel lane: its own copy of the ping-pong line store and a source tracker.
// Walks the source pixel of its slot one word per issue. Uses rlwr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlwr_lane
	import rlwr_pkg::*;
#(
	parameter int LINE_WIDTH      = LINE_WIDTH_DEF,
	parameter int PIXELS_PER_WORD = PIXELS_PER_WORD_DEF,
	parameter int LANE            = 0
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [$clog2(2 * ((LINE_WIDTH + PIXELS_PER_WORD - 1) / PIXELS_PER_WORD))-1:0]
	                               wr_addr,
	input  wire logic [WORD_W-1:0] wr_data,
	input  wire lane_ctrl_t        ctrl,
	input  wire logic [$clog2((LINE_WIDTH + PIXELS_PER_WORD - 1) / PIXELS_PER_WORD)-1:0] s_word,
	input  wire logic [(PIXELS_PER_WORD > 1 ? $clog2(PIXELS_PER_WORD) : 1)-1:0]            s_bsel,
	output logic [PIXEL_W-1:0]     pix
);

	localparam int WPR = (LINE_WIDTH + PIXELS_PER_WORD - 1) / PIXELS_PER_WORD;
	localparam int WW  = $clog2(WPR);
	localparam int BW  = PIXELS_PER_WORD > 1 ? $clog2(PIXELS_PER_WORD) : 1;
	localparam int AW  = $clog2(2 * WPR);
	localparam int IW  = $clog2(LINE_WIDTH + PIXELS_PER_WORD);
	localparam logic [IW-1:0] LW_I  = IW'(LINE_WIDTH);
	localparam logic [IW-1:0] PPW_I = IW'(PIXELS_PER_WORD);
	localparam logic [BW:0]   PPW_B = (BW + 1)'(PIXELS_PER_WORD);

	logic [WORD_W-1:0] mem [2 * WPR];
	logic [WORD_W-1:0] rd_s1;
	logic [BW-1:0]     bsel_s1;

	logic [IW-1:0] pos_q;
	logic [WW-1:0] word_q;
	logic [BW-1:0] bsel_q;

	logic [IW-1:0] pos0;
	logic [IW-1:0] pos0_w;
	logic [BW:0]   bsum;
	logic [IW-1:0] pos_n;
	logic [IW-1:0] pos_nw;
	logic [AW-1:0] rd_addr;

	assign pos0   = IW'(LANE) + IW'(s_word) * PPW_I + IW'(s_bsel);
	assign pos0_w = pos0 - LW_I;
	assign bsum   = (BW + 1)'(LANE) + (BW + 1)'(s_bsel);
	assign pos_n  = pos_q + PPW_I;
	assign pos_nw = pos_n - LW_I;
	assign rd_addr = (ctrl.bank ? AW'(WPR) : AW'(0)) + AW'(word_q);

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			if (pos0 >= LW_I) begin
				pos_q  <= pos0_w;
				word_q <= '0;
				bsel_q <= BW'(pos0_w);
			end else if (bsum >= PPW_B) begin
				pos_q  <= pos0;
				word_q <= s_word + 1'b1;
				bsel_q <= BW'(bsum - PPW_B);
			end else begin
				pos_q  <= pos0;
				word_q <= s_word;
				bsel_q <= BW'(bsum);
			end
		end else if (ctrl.issue) begin
			if (pos_n >= LW_I) begin
				pos_q  <= pos_nw;
				word_q <= '0;
				bsel_q <= BW'(pos_nw);
			end else begin
				pos_q  <= pos_n;
				word_q <= word_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctrl.issue) begin
			rd_s1   <= mem[rd_addr];
			bsel_s1 <= bsel_q;
		end
	end

	assign pix = rd_s1[PIXEL_W * bsel_s1 +: PIXEL_W];

endmodule

`default_nettype wire

// File: rtl/raster_line_wave_rotator_unit.sv
// Top level of the raster line wave rotator: frame and row control, wave registers,
// emit sequencer and the merge of lane pixels into output words. Uses rlwr_pkg,
// rlwr_shift_calc and rlwr_lane.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+------------------------
//  pixels   | pixel_valid  | pixel_stall  | pixel_word, frame_start
//  results  | result_valid | result_stall | out_word, row_end
//  config   | cfg_we       | -            | cfg_index, cfg_data
//
// Words of a row go in at one per cycle while pixel_stall is low. After a row's last
// word the shift sequencer steps through its states, and its done starts the read-out;
// the row is then read at one word per cycle unless result_stall holds it, through one
// store read port per lane. pixel_stall is high from the last word until the final read.
// result_stall holds the read pipeline in place. Reset clears control state only;
// the line store needs no clearing since every entry is written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module raster_line_wave_rotator_unit
	import rlwr_pkg::*;
#(
	parameter int LINE_WIDTH      = LINE_WIDTH_DEF,
	parameter int LINE_COUNT      = LINE_COUNT_DEF,
	parameter int PIXELS_PER_WORD = PIXELS_PER_WORD_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pixel_valid,
	output logic                   pixel_stall,
	input  wire logic [WORD_W-1:0] pixel_word,
	input  wire logic              frame_start,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic [WORD_W-1:0]      out_word,
	output logic                   row_end,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	localparam int WPR = (LINE_WIDTH + PIXELS_PER_WORD - 1) / PIXELS_PER_WORD;
	localparam int WW  = $clog2(WPR);
	localparam int BW  = PIXELS_PER_WORD > 1 ? $clog2(PIXELS_PER_WORD) : 1;
	localparam int AW  = $clog2(2 * WPR);
	localparam int LAST_LIVE = LINE_WIDTH - (WPR - 1) * PIXELS_PER_WORD;
	localparam logic [WW-1:0]    WPR_LAST = WW'(WPR - 1);
	localparam logic [ROW_W-1:0] LC_T     = ROW_W'(LINE_COUNT);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [AMP_W-1:0]   amp_q;
	logic [AMP_W-1:0]   step_q;
	logic               armed_q;
	logic [TABLE_W-1:0] phase_q;
	logic [ROW_W-1:0]   row_q;
	logic [WW-1:0]      wc_q;
	logic               waved_q;
	logic               bank_q;
	logic [WW-1:0]      ec_q;

	logic               valid_s1;
	logic               last_s1;
	logic               out_valid_q;
	logic [WORD_W-1:0]  out_word_q;
	logic               row_end_q;

	logic               accept;
	logic               adv;
	logic               issue;
	logic               row_last;
	logic [AMP_W-1:0]   amp_sum;
	logic [AMP_W-1:0]   amp_eff;
	logic               amp_stop;
	logic [TABLE_W-1:0] phase_eff;
	logic               waved_eff;
	logic [ROW_W-1:0]   row_eff;
	logic [WW-1:0]      wc_eff;
	logic [AW-1:0]      wr_addr;
	logic [TABLE_W-1:0] k;
	logic               calc_done;
	logic [WW-1:0]      s_word;
	logic [BW-1:0]      s_bsel;
	lane_ctrl_t         ctrl;
	logic [PIXEL_W-1:0] pix [PIXELS_PER_WORD];
	logic [WORD_W-1:0]  merged;

	assign pixel_stall = state_q != ST_IDLE;
	assign accept      = pixel_valid && !pixel_stall;
	assign adv         = !out_valid_q || !result_stall;
	assign issue       = state_q == ST_EMIT && adv;

	// frame start: phase, amplitude and wave decision before this word is taken
	assign amp_sum   = armed_q ? amp_q + step_q : amp_q;
	assign amp_stop  = amp_sum == '0 || amp_sum >= AMP_LIMIT;
	assign amp_eff   = frame_start ? (amp_stop ? '0 : amp_sum) : amp_q;
	assign phase_eff = (frame_start && waved_q) ? phase_q + 1'b1 : phase_q;
	assign waved_eff = frame_start ? !amp_stop : waved_q;
	assign row_eff   = frame_start ? '0 : row_q;
	assign wc_eff    = frame_start ? '0 : wc_q;
	assign row_last  = wc_eff == WPR_LAST;
	assign wr_addr   = (row_eff[0] ? AW'(WPR) : AW'(0)) + AW'(wc_eff);
	assign k         = phase_eff + row_eff[TABLE_W-1:0];

	assign ctrl.init  = calc_done;
	assign ctrl.issue = issue;
	assign ctrl.bank  = bank_q;

	rlwr_shift_calc #(
		.LINE_WIDTH      (LINE_WIDTH),
		.PIXELS_PER_WORD (PIXELS_PER_WORD)
	) u_shift (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && row_last),
		.amp    (amp_eff),
		.k      (k),
		.enable (waved_eff && row_eff < LC_T),
		.done   (calc_done),
		.s_word (s_word),
		.s_bsel (s_bsel)
	);

	for (genvar j = 0; j < PIXELS_PER_WORD; j++) begin : g_lane
		rlwr_lane #(
			.LINE_WIDTH      (LINE_WIDTH),
			.PIXELS_PER_WORD (PIXELS_PER_WORD),
			.LANE            (j)
		) u_lane (
			.clk     (clk),
			.wr_en   (accept),
			.wr_addr (wr_addr),
			.wr_data (pixel_word),
			.ctrl    (ctrl),
			.s_word  (s_word),
			.s_bsel  (s_bsel),
			.pix     (pix[j])
		);
	end

	// slots past the line end on the last word are zero
	always_comb begin
		merged = '0;
		for (int j = 0; j < PIXELS_PER_WORD; j++) begin
			if (!(last_s1 && j >= LAST_LIVE)) begin
				merged[PIXEL_W*j +: PIXEL_W] = pix[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			amp_q       <= '0;
			step_q      <= '0;
			armed_q     <= 1'b0;
			phase_q     <= '0;
			row_q       <= '0;
			wc_q        <= '0;
			waved_q     <= 1'b0;
			bank_q      <= 1'b0;
			ec_q        <= '0;
			valid_s1    <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						amp_q   <= amp_eff;
						phase_q <= phase_eff;
						waved_q <= waved_eff;
						if (frame_start && amp_stop) begin
							step_q  <= '0;
							armed_q <= 1'b0;
						end
						if (row_last) begin
							wc_q    <= '0;
							row_q   <= (row_eff == ROW_MAX) ? ROW_MAX : row_eff + 1'b1;
							bank_q  <= row_eff[0];
							state_q <= ST_CALC;
						end else begin
							wc_q  <= wc_eff + 1'b1;
							row_q <= row_eff;
						end
					end
				end
				ST_CALC: begin
					ec_q <= '0;
					if (calc_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (issue) begin
						ec_q <= ec_q + 1'b1;
						if (ec_q == WPR_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cfg_we) begin
				case (cfg_index)
					CFG_WAVE_START: amp_q <= cfg_data;
					CFG_WAVE_STEP: begin
						step_q  <= cfg_data;
						armed_q <= cfg_data != '0;
					end
					default: ;
				endcase
			end

			if (adv) begin
				valid_s1    <= issue;
				out_valid_q <= valid_s1;
			end
			if (issue) begin
				last_s1 <= ec_q == WPR_LAST;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_word_q <= merged;
			row_end_q  <= last_s1;
		end
	end

	assign result_valid = out_valid_q;
	assign out_word     = out_word_q;
	assign row_end      = row_end_q;

endmodule

`default_nettype wire
